// File: hdl/session_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// Session frame parser assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SESSION_FRAME_PARSER_ASSERT_SVH
`define SESSION_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication.
`define SFP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("session_frame_parser: check failed");

// Next-cycle implication.
`define SFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("session_frame_parser: check failed");

`endif

// File: hdl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Types and constants of the session frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

  localparam int unsigned LenW  = 17;
  localparam int unsigned ConsW = 18;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_NOTCONV = 2'd2,
    ST_BADTYPE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    TAG_PAYLOAD       = 3'd0,
    TAG_CALLED_LABEL  = 3'd1,
    TAG_CALLED_NAME   = 3'd2,
    TAG_CALLING_LABEL = 3'd3,
    TAG_CALLING_NAME  = 3'd4
  } tag_e;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_e;

  localparam logic [7:0] TypeMessage   = 8'h00;
  localparam logic [7:0] TypeRequest   = 8'h81;
  localparam logic [7:0] TypePosResp   = 8'h82;
  localparam logic [7:0] TypeNegResp   = 8'h83;
  localparam logic [7:0] TypeRetarget  = 8'h84;
  localparam logic [7:0] TypeKeepalive = 8'h85;

  localparam logic [LenW-1:0] ReqLenShort = 17'd68;
  localparam logic [LenW-1:0] ReqLenLong  = 17'd72;

  typedef struct packed {
    logic             kind;
    logic [7:0]       body_byte;
    logic [2:0]       tag;
    logic [1:0]       status;
    logic [7:0]       msg_type;
    logic             short_keepalive;
    logic [LenW-1:0]  body_length;
    logic [ConsW-1:0] consumed;
    logic [7:0]       refusal_code;
    logic [31:0]      redirect_ip;
    logic [15:0]      redirect_port;
    logic             last;
  } result_t;

  function automatic logic [1:0] hdr_status(logic [7:0] ty, logic [LenW-1:0] len);
    logic [1:0] st;
    unique case (ty)
      TypeMessage:   st = ST_OK;
      TypeRequest:   st = (len == ReqLenShort || len == ReqLenLong) ? ST_OK : ST_NOTCONV;
      TypePosResp,
      TypeKeepalive: st = (len == '0) ? ST_OK : ST_NOTCONV;
      TypeNegResp:   st = (len == 17'd1) ? ST_OK : ST_NOTCONV;
      TypeRetarget:  st = (len == 17'd6) ? ST_OK : ST_NOTCONV;
      default:       st = ST_BADTYPE;
    endcase
    return st;
  endfunction

  function automatic result_t mk_summary(logic [1:0] st, logic [7:0] ty, logic ska,
                                         logic [LenW-1:0] len, logic [ConsW-1:0] cons,
                                         logic [7:0] refusal, logic [31:0] ip,
                                         logic [15:0] port);
    result_t r;
    r = '0;
    r.kind            = 1'b1;
    r.status          = st;
    r.msg_type        = ty;
    r.short_keepalive = ska;
    r.body_length     = len;
    r.consumed        = cons;
    if (st == ST_OK && ty == TypeNegResp) r.refusal_code = refusal;
    if (st == ST_OK && ty == TypeRetarget) begin
      r.redirect_ip   = ip;
      r.redirect_port = port;
    end
    r.last = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/session_frame_parser.sv
// ----------------------------------------------------------------------------
// Session frame parser
// Parses session service headers from a byte stream, tags body bytes and
// emits one summary per packet.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake                  | Payload
//  ---------+-----+----------------------------+-------------------------------
//  in       | in  | in_valid_i / in_ready_o    | data_byte_i, seg_end_i
//  out      | out | out_valid_o / out_ready_i  | out_kind_o .. last_o
//
//  One byte is accepted per cycle while in_ready_o is high; each byte yields
//  0, 1 or 2 results. Results wait in a 4-entry output queue; a request is
//  taken while at most 2 entries are held, so the two results of a packet's
//  final body byte always fit. Each result is registered in the queue first.
//  Reset empties the queue and returns the parser to header parsing.
//  Output stalls back up into in_ready_o once the queue is nearly full.
// ----------------------------------------------------------------------------
`default_nettype none

module session_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        seg_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             out_kind_o,
  output logic [7:0]       body_byte_o,
  output logic [2:0]       field_tag_o,
  output logic [1:0]       status_o,
  output logic [7:0]       msg_type_o,
  output logic             short_keepalive_o,
  output logic [sfp_pkg::LenW-1:0]  body_length_o,
  output logic [sfp_pkg::ConsW-1:0] consumed_o,
  output logic [7:0]       refusal_code_o,
  output logic [31:0]      redirect_ip_o,
  output logic [15:0]      redirect_port_o,
  output logic             last_o
);
  import sfp_pkg::*;

  `include "session_frame_parser_assert.svh"

  phase_e          phase_q, phase_d;
  logic            seg_start_q, seg_start_d;
  logic [1:0]      hdr_cnt_q, hdr_cnt_d;
  logic [7:0]      type_q, type_d;
  logic [LenW-1:0] length_q, length_d;
  logic [LenW-1:0] body_cnt_q, body_cnt_d;
  logic [1:0]      pend_q, pend_d;
  logic [7:0]      refusal_q, refusal_d;
  logic [31:0]     ip_q, ip_d;
  logic [15:0]     port_q, port_d;

  result_t         res_a, res_b;
  logic [1:0]      push_cnt;
  logic            acc_in, pop;
  logic            req_ok;
  logic            done;

  result_t         fifo_q [4];
  logic [1:0]      wr_ptr_q, rd_ptr_q;
  logic [2:0]      count_q;
  result_t         head;

  assign acc_in     = in_valid_i && in_ready_o;
  assign pop        = out_valid_o && out_ready_i;
  assign in_ready_o = (count_q < 3'd3);
  assign req_ok     = (type_q == TypeRequest) &&
                      (length_q == ReqLenShort || length_q == ReqLenLong);

  always_comb begin
    phase_d     = phase_q;
    seg_start_d = seg_start_q;
    hdr_cnt_d   = hdr_cnt_q;
    type_d      = type_q;
    length_d    = length_q;
    body_cnt_d  = body_cnt_q;
    pend_d      = pend_q;
    refusal_d   = refusal_q;
    ip_d        = ip_q;
    port_d      = port_q;
    res_a       = '0;
    res_b       = '0;
    push_cnt    = 2'd0;
    done        = 1'b0;
    if (acc_in) begin
      seg_start_d = seg_end_i;
      unique case (phase_q)
        PH_HEADER: begin
          if (hdr_cnt_q == 2'd0 && seg_start_q && seg_end_i && data_byte_i == 8'h00) begin
            res_a    = mk_summary(ST_OK, TypeMessage, 1'b1, '0, 18'd1, '0, '0, '0);
            push_cnt = 2'd1;
          end else begin
            unique case (hdr_cnt_q)
              2'd0: begin
                type_d     = data_byte_i;
                length_d   = '0;
                body_cnt_d = '0;
                pend_d     = ST_OK;
                refusal_d  = '0;
                ip_d       = '0;
                port_d     = '0;
              end
              2'd1:    length_d = {data_byte_i[0], 16'h0000};
              2'd2:    length_d = length_q | {1'b0, data_byte_i, 8'h00};
              default: length_d = length_q | {9'h000, data_byte_i};
            endcase
            if (hdr_cnt_q != 2'd3) begin
              if (seg_end_i) begin
                res_a     = mk_summary(ST_MISSING, type_d, 1'b0, '0,
                                       {16'h0000, hdr_cnt_q} + 18'd1, '0, '0, '0);
                push_cnt  = 2'd1;
                hdr_cnt_d = 2'd0;
              end else begin
                hdr_cnt_d = hdr_cnt_q + 2'd1;
              end
            end else begin
              hdr_cnt_d = 2'd0;
              pend_d    = hdr_status(type_q, length_d);
              if (length_d == '0) begin
                res_a    = mk_summary(pend_d, type_q, 1'b0, '0, 18'd4,
                                      refusal_q, ip_q, port_q);
                push_cnt = 2'd1;
              end else if (seg_end_i) begin
                res_a    = mk_summary(ST_MISSING, type_q, 1'b0, length_d, 18'd4,
                                      refusal_q, ip_q, port_q);
                push_cnt = 2'd1;
              end else begin
                phase_d    = PH_BODY;
                body_cnt_d = '0;
              end
            end
          end
        end
        default: begin
          res_a           = '0;
          res_a.body_byte = data_byte_i;
          res_a.tag       = TAG_PAYLOAD;
          if (req_ok) begin
            priority if (body_cnt_q == 17'd0) begin
              res_a.tag = TAG_CALLED_LABEL;
            end else if (body_cnt_q <= 17'd32) begin
              res_a.tag = TAG_CALLED_NAME;
            end else if (body_cnt_q == 17'd34) begin
              res_a.tag = TAG_CALLING_LABEL;
            end else if (body_cnt_q >= 17'd35 && body_cnt_q <= 17'd66) begin
              res_a.tag = TAG_CALLING_NAME;
            end else if (data_byte_i != 8'h00 && pend_q == ST_OK) begin
              pend_d = ST_NOTCONV;
            end
          end else if (type_q == TypeNegResp && body_cnt_q == 17'd0) begin
            refusal_d = data_byte_i;
          end else if (type_q == TypeRetarget && body_cnt_q < 17'd4) begin
            ip_d = {ip_q[23:0], data_byte_i};
          end else if (type_q == TypeRetarget && body_cnt_q < 17'd6) begin
            port_d = {port_q[7:0], data_byte_i};
          end
          body_cnt_d = body_cnt_q + 17'd1;
          done       = (body_cnt_d == length_q);
          res_a.last = !(done || seg_end_i);
          push_cnt   = 2'd1;
          if (done) begin
            res_b    = mk_summary(pend_d, type_q, 1'b0, length_q,
                                  {1'b0, length_q} + 18'd4, refusal_d, ip_d, port_d);
            phase_d  = PH_HEADER;
            push_cnt = 2'd2;
          end else if (seg_end_i) begin
            res_b    = mk_summary(ST_MISSING, type_q, 1'b0, length_q,
                                  {1'b0, body_cnt_d} + 18'd4, refusal_d, ip_d, port_d);
            phase_d  = PH_HEADER;
            push_cnt = 2'd2;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      seg_start_q <= 1'b1;
      hdr_cnt_q   <= '0;
      type_q      <= '0;
      length_q    <= '0;
      body_cnt_q  <= '0;
      pend_q      <= ST_OK;
      refusal_q   <= '0;
      ip_q        <= '0;
      port_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      seg_start_q <= seg_start_d;
      hdr_cnt_q   <= hdr_cnt_d;
      type_q      <= type_d;
      length_q    <= length_d;
      body_cnt_q  <= body_cnt_d;
      pend_q      <= pend_d;
      refusal_q   <= refusal_d;
      ip_q        <= ip_d;
      port_q      <= port_d;
    end
  end

  // output queue
  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) fifo_q[wr_ptr_q] <= res_a;
    if (push_cnt == 2'd2) fifo_q[wr_ptr_q + 2'd1] <= res_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_cnt;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      count_q  <= count_q + {1'b0, push_cnt} - {2'b00, pop};
    end
  end

  assign head              = fifo_q[rd_ptr_q];
  assign out_valid_o       = (count_q != 3'd0);
  assign out_kind_o        = head.kind;
  assign body_byte_o       = head.body_byte;
  assign field_tag_o       = head.tag;
  assign status_o          = head.status;
  assign msg_type_o        = head.msg_type;
  assign short_keepalive_o = head.short_keepalive;
  assign body_length_o     = head.body_length;
  assign consumed_o        = head.consumed;
  assign refusal_code_o    = head.refusal_code;
  assign redirect_ip_o     = head.redirect_ip;
  assign redirect_port_o   = head.redirect_port;
  assign last_o            = head.last;

  `SFP_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= 3'd4)
  `SFP_ASSERT_IMPLY(a_summary_last, out_valid_o && out_kind_o, last_o)
  `SFP_ASSERT_IMPLY(a_body_no_hdr, phase_q == PH_BODY, hdr_cnt_q == 2'd0)
  `SFP_ASSERT_NEXT(a_seg_start, acc_in && seg_end_i, seg_start_q && phase_q == PH_HEADER)

endmodule

`default_nettype wire
